// ===== rtl/mbet_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies; imported by the pixel mapper and the top level.
package mbet_pkg;

    // Fixed field widths of the configuration and result ports.
    localparam int ITER_W = 16;
    localparam int STEP_W = 28;
    localparam int CFG_DW = 28;
    localparam int CFG_IW = 2;

    typedef logic [CFG_IW-1:0] t_cfg_idx;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [ITER_W-1:0] t_iter;

    // Configuration register indexes.
    localparam t_cfg_idx REG_BASE_COL   = 2'd0;
    localparam t_cfg_idx REG_BASE_ROW   = 2'd1;
    localparam t_cfg_idx REG_PIXEL_STEP = 2'd2;
    localparam t_cfg_idx REG_MAX_ITER   = 2'd3;

    // Register reset values.
    localparam int    BASE_COL_RST = 800;
    localparam int    BASE_ROW_RST = 400;
    localparam t_step STEP_RST     = 28'd671089;
    localparam t_iter ITER_RST     = 16'd16000;

    // Escape radius squared, in integer units.
    localparam int ESC_LIMIT = 4;

endpackage

// ===== rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit: one pixel per request, results as single-cycle strobes.
// Depends on mbet_pkg, mbet_cmap and mbet_qmul.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result is strobed on o_done for one cycle, which the receiver must
// take as it comes. The pixel is first mapped to c, then each iteration forms
// three products (re*im, re*re, im*im) on one shared multiplier, which works
// through the digit pairs of its operands, ND being the number of digits of at
// most 32 bits in a FRAC_BITS+4 bit operand. A point inside the set runs all
// max_iter iterations. No new request is taken until the result is strobed,
// as the one shared multiplier serves a single pixel at a time.
module mandelbrot_escape_time
    import mbet_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DW-1:0]     i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    output logic                  o_done,
    output logic [ITER_W-1:0]     o_escape_count,
    output logic                  o_inside_res
);

    localparam int W  = FRAC_BITS + 4;
    localparam int EW = W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMAP = 3'd1;
    localparam logic [2:0] S_RI   = 3'd2;
    localparam logic [2:0] S_RR   = 3'd3;
    localparam logic [2:0] S_II   = 3'd4;

    localparam logic [W:0] ESC_Q = (W + 1)'(ESC_LIMIT) << FRAC_BITS;
    localparam logic signed [EW-1:0] Q_HI = (EW'(1) <<< (W - 1)) - EW'(1);
    localparam logic signed [EW-1:0] Q_LO = -(EW'(1) <<< (W - 1));

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic                   r_pend;
    logic [COORD_BITS-1:0]  r_base_col;
    logic [COORD_BITS-1:0]  r_base_row;
    t_step                  r_pixel_step;
    t_iter                  r_max_iter;
    logic signed [W-1:0]    r_re;
    logic signed [W-1:0]    r_im;
    logic [W-1:0]           r_rr;
    logic [W-1:0]           r_ii;
    t_iter                  r_k;
    logic                   r_done;
    t_iter                  r_count;
    logic                   r_inside;

    logic                   w_accept;
    logic                   w_cm_done;
    logic signed [W-1:0]    w_c_re;
    logic signed [W-1:0]    w_c_im;
    logic                   w_mul_start;
    logic                   w_mul_done;
    logic [W-1:0]           w_mul_a;
    logic [W-1:0]           w_mul_b;
    logic [W-1:0]           w_prod;
    logic [W-1:0]           w_mag_re;
    logic [W-1:0]           w_mag_im;
    logic signed [EW-1:0]   w_ri_m;
    logic signed [EW-1:0]   w_ri;
    logic signed [EW-1:0]   w_sum_re;
    logic signed [EW-1:0]   w_sum_im;
    logic signed [W-1:0]    w_new_re;
    logic signed [W-1:0]    w_new_im;
    logic [W:0]             w_m2;
    logic                   w_esc;
    logic                   w_last_k;
    logic                   w_finish;

    // Clamp a widened sum back to the Q4 range.
    function automatic logic signed [W-1:0] sat_q(input logic signed [EW-1:0] v);
        if (v > Q_HI) begin
            return Q_HI[W-1:0];
        end else if (v < Q_LO) begin
            return Q_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_col   <= COORD_BITS'(BASE_COL_RST);
            r_base_row   <= COORD_BITS'(BASE_ROW_RST);
            r_pixel_step <= STEP_RST;
            r_max_iter   <= ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BASE_COL:   r_base_col   <= i_cfg_data[COORD_BITS-1:0];
                REG_BASE_ROW:   r_base_row   <= i_cfg_data[COORD_BITS-1:0];
                REG_PIXEL_STEP: r_pixel_step <= i_cfg_data[STEP_W-1:0];
                REG_MAX_ITER:   r_max_iter   <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start & ~busy;

    // Pixel-to-plane mapping.
    mbet_cmap #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_cmap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_base_col (r_base_col),
        .i_base_row (r_base_row),
        .i_step     (r_pixel_step),
        .o_done     (w_cm_done),
        .o_c_re     (w_c_re),
        .o_c_im     (w_c_im)
    );

    // Operand selection for the shared multiplier; z holds still during a product.
    assign w_mag_re    = r_re[W-1] ? W'(-r_re) : W'(r_re);
    assign w_mag_im    = r_im[W-1] ? W'(-r_im) : W'(r_im);
    assign w_mul_a     = (r_state == S_II) ? w_mag_im : w_mag_re;
    assign w_mul_b     = (r_state == S_RR) ? w_mag_re : w_mag_im;
    assign w_mul_start = !r_pend && ((r_state == S_RI) || (r_state == S_RR)
                                     || (r_state == S_II));

    mbet_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Next iterate from the stored squares and the signed cross product.
    assign w_ri_m   = $signed(EW'(w_prod));
    assign w_ri     = (r_re[W-1] ^ r_im[W-1]) ? -w_ri_m : w_ri_m;
    assign w_sum_re = $signed(EW'(r_rr)) - $signed(EW'(r_ii)) + EW'(w_c_re);
    assign w_sum_im = (w_ri <<< 1) + EW'(w_c_im);
    assign w_new_re = sat_q(w_sum_re);
    assign w_new_im = sat_q(w_sum_im);

    // Escape test on the squares of the new iterate, and the iteration limit.
    assign w_m2     = (W + 1)'(r_rr) + (W + 1)'(w_prod);
    assign w_esc    = (w_m2 > ESC_Q);
    assign w_last_k = ((ITER_W + 1)'(r_k) + (ITER_W + 1)'(1)) == (ITER_W + 1)'(r_max_iter);
    assign w_finish = ((r_state == S_CMAP) && w_cm_done && (r_max_iter == '0))
                   || ((r_state == S_II) && w_mul_done && (w_esc || w_last_k));

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                n_state = S_CMAP;
            end
            S_CMAP: if (w_cm_done) begin
                n_state = (r_max_iter == '0) ? S_IDLE : S_RI;
            end
            S_RI: if (w_mul_done) begin
                n_state = S_RR;
            end
            S_RR: if (w_mul_done) begin
                n_state = S_II;
            end
            S_II: if (w_mul_done) begin
                n_state = (w_esc || w_last_k) ? S_IDLE : S_RI;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_finish;
            if (w_mul_start) begin
                r_pend <= 1'b1;
            end else if (w_mul_done) begin
                r_pend <= 1'b0;
            end
        end
    end

    // Iterate, squares, counter and result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CMAP: if (w_cm_done) begin
                r_re     <= '0;
                r_im     <= '0;
                r_rr     <= '0;
                r_ii     <= '0;
                r_k      <= '0;
                r_count  <= '0;
                r_inside <= 1'b1;
            end
            S_RI: if (w_mul_done) begin
                r_re <= w_new_re;
                r_im <= w_new_im;
            end
            S_RR: if (w_mul_done) begin
                r_rr <= w_prod;
            end
            S_II: if (w_mul_done) begin
                r_ii <= w_prod;
                if (w_esc) begin
                    r_count  <= r_k;
                    r_inside <= 1'b0;
                end else if (w_last_k) begin
                    r_count  <= r_max_iter;
                    r_inside <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_done         = r_done;
    assign o_escape_count = r_count;
    assign o_inside_res   = r_inside;

`ifndef SYNTHESIS
    // A result is only strobed once the unit has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while busy");

    // A taken request always makes the unit busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but unit not busy");

    // An inside point reports the full iteration limit.
    a_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inside_res) |-> (o_escape_count == r_max_iter))
        else $error("inside result with wrong count");

    // An escaped point reports a count below the limit.
    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_inside_res) |-> (o_escape_count < r_max_iter))
        else $error("escape count not below limit");
`endif

endmodule

// ===== rtl/mbet_qmul.sv =====
// Shared fixed-point magnitude multiplier: exact product, truncated to
// FRAC_BITS fraction bits and clamped to 8. No package dependencies.
module mbet_qmul #(
    parameter int FRAC_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FRAC_BITS+3:0] i_a,
    input  logic [FRAC_BITS+3:0] i_b,
    output logic                 o_done,
    output logic [FRAC_BITS+3:0] o_prod
);

    // Operands are split into ND digits of at most 32 bits each.
    localparam int MW = FRAC_BITS + 4;
    localparam int ND = (MW + 31) / 32;
    localparam int DW = (MW + ND - 1) / ND;
    localparam int PW = ND * DW;
    localparam int AW = 2 * PW;
    localparam int IW = (ND > 1) ? $clog2(ND) : 1;
    localparam logic [AW-1:0] QMAX = AW'(1) << (MW - 1);

    logic          r_act;
    logic          r_done;
    logic [IW-1:0] r_ia;
    logic [IW-1:0] r_ib;
    logic [IW-1:0] n_ia;
    logic [IW-1:0] n_ib;
    logic [IW-1:0] w_ia;
    logic [IW-1:0] w_ib;
    logic          w_go;
    logic          w_last;
    logic [PW-1:0] w_ap;
    logic [PW-1:0] w_bp;
    logic [DW-1:0] w_ad;
    logic [DW-1:0] w_bd;
    logic [2*DW-1:0] w_pp;
    logic [AW-1:0] w_pps;
    logic [AW-1:0] r_acc;
    logic [AW-1:0] n_acc;
    logic [AW-1:0] w_trunc;

    // Digit indexes restart at zero on every new request.
    assign w_go   = i_start | r_act;
    assign w_ia   = i_start ? '0 : r_ia;
    assign w_ib   = i_start ? '0 : r_ib;
    assign w_last = (w_ia == IW'(ND - 1)) && (w_ib == IW'(ND - 1));

    // One digit-by-digit partial product per cycle, shifted into place.
    assign w_ap  = PW'(i_a);
    assign w_bp  = PW'(i_b);
    assign w_ad  = w_ap[DW*int'(w_ia) +: DW];
    assign w_bd  = w_bp[DW*int'(w_ib) +: DW];
    assign w_pp  = w_ad * w_bd;
    assign w_pps = AW'(w_pp) << (DW * (int'(w_ia) + int'(w_ib)));
    assign n_acc = (i_start ? '0 : r_acc) + w_pps;

    // Step through the digit pairs, inner index first.
    always_comb begin
        n_ia = w_ia + 1'b1;
        n_ib = w_ib;
        if (w_ia == IW'(ND - 1)) begin
            n_ia = '0;
            n_ib = w_ib + 1'b1;
        end
        if (w_last) begin
            n_ib = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_ia   <= '0;
            r_ib   <= '0;
        end else begin
            r_done <= w_go & w_last;
            r_act  <= w_go & ~w_last;
            if (w_go) begin
                r_ia <= n_ia;
                r_ib <= n_ib;
            end
        end
    end

    // Product accumulator.
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_acc <= n_acc;
        end
    end

    // Truncate to the fixed-point grid and clamp the magnitude to 8.
    assign w_trunc = r_acc >> FRAC_BITS;
    assign o_prod  = (w_trunc > QMAX) ? QMAX[MW-1:0] : w_trunc[MW-1:0];
    assign o_done  = r_done;

endmodule

// ===== rtl/mbet_cmap.sv =====
// Pixel-to-plane mapper: forms c_re and then c_im with one multiplier.
// Depends on mbet_pkg for the step width.
module mbet_cmap
    import mbet_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [COORD_BITS-1:0]       i_col,
    input  logic [COORD_BITS-1:0]       i_row,
    input  logic [COORD_BITS-1:0]       i_base_col,
    input  logic [COORD_BITS-1:0]       i_base_row,
    input  t_step                       i_step,
    output logic                        o_done,
    output logic signed [FRAC_BITS+3:0] o_c_re,
    output logic signed [FRAC_BITS+3:0] o_c_im
);

    localparam int W   = FRAC_BITS + 4;
    localparam int DFW = COORD_BITS + 1;
    localparam int PW  = DFW + STEP_W + 1;
    localparam int XW  = ((PW > W) ? PW : W) + 1;
    localparam logic signed [XW-1:0] C_HI = (XW'(1) <<< (W - 1)) - XW'(1);
    localparam logic signed [XW-1:0] C_LO = -(XW'(1) <<< (W - 1));

    logic                   r_ph;
    logic                   r_done;
    logic [COORD_BITS-1:0]  r_row;
    logic signed [DFW-1:0]  w_diff;
    logic signed [PW-1:0]   w_prod;
    logic signed [XW-1:0]   w_px;
    logic signed [W-1:0]    w_sat;
    logic signed [W-1:0]    r_c_re;
    logic signed [W-1:0]    r_c_im;

    // The column is mapped first, then the latched row.
    assign w_diff = r_ph ? ($signed({1'b0, i_base_row}) - $signed({1'b0, r_row}))
                         : ($signed({1'b0, i_col}) - $signed({1'b0, i_base_col}));
    assign w_prod = w_diff * $signed({1'b0, i_step});
    assign w_px   = XW'(w_prod);

    // Saturate to the Q4 range.
    always_comb begin
        if (w_px > C_HI) begin
            w_sat = C_HI[W-1:0];
        end else if (w_px < C_LO) begin
            w_sat = C_LO[W-1:0];
        end else begin
            w_sat = w_px[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= i_start;
            r_done <= r_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_row  <= i_row;
            r_c_re <= w_sat;
        end
        if (r_ph) begin
            r_c_im <= w_sat;
        end
    end

    assign o_done = r_done;
    assign o_c_re = r_c_re;
    assign o_c_im = r_c_im;

endmodule
